/* rtl/cssf_pkg.sv */
`default_nettype none

package cssf_pkg;

  localparam int unsigned NumDigits = 6;

  typedef enum logic [1:0] {
    CMD_TIME = 2'd0,
    CMD_DATE = 2'd1,
    CMD_MSG  = 2'd2,
    CMD_NONE = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    TF_24H       = 2'd0,
    TF_12H       = 2'd1,
    TF_12H_BLANK = 2'd2,
    TF_12H_ALT   = 2'd3
  } time_format_e;

  localparam logic CFG_TIME_FORMAT = 1'b0;
  localparam logic CFG_DATE_FORMAT = 1'b1;

  localparam logic DF_DMY = 1'b0;

  // one decimal digit for a lane; blank shows pattern 0
  typedef struct packed {
    logic [3:0] value;
    logic       blank;
  } digit_t;

  // word handed from the front end to the lanes
  typedef struct packed {
    command_e                       cmd;
    logic [NumDigits-1:0]           dots;
    logic [NumDigits-1:0][7:0]      chars;   // index = segment position
    digit_t [NumDigits-1:0]         digits;  // index = segment position
  } lane_word_t;

  // tens/ones of a value below 64: tens = (x * 13) >> 7
  function automatic digit_t [1:0] split_small(input logic [5:0] x);
    logic [10:0]     prod;
    logic [3:0]      tens;
    logic [7:0]      tens10;
    digit_t [1:0]    res;
    prod   = {5'd0, x} * 11'd13;
    tens   = prod[10:7];
    tens10 = {4'd0, tens} * 8'd10;
    res[1] = '{value: tens, blank: 1'b0};
    res[0] = '{value: x[3:0] - tens10[3:0], blank: 1'b0};
    return res;
  endfunction

  function automatic logic [7:0] glyph_of_digit(input logic [3:0] v);
    logic [7:0] g;
    case (v)
      4'd0:    g = 8'hFC;
      4'd1:    g = 8'h60;
      4'd2:    g = 8'hDA;
      4'd3:    g = 8'hF2;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'hB6;
      4'd6:    g = 8'hBE;
      4'd7:    g = 8'hE0;
      4'd8:    g = 8'hFE;
      4'd9:    g = 8'hF6;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] glyph_of_char(input logic [7:0] c);
    logic [7:0] g;
    if (c < 8'd10) begin
      g = glyph_of_digit(c[3:0]);
    end else begin
      case (c)
        8'h41:   g = 8'hEE;  // A
        8'h42:   g = 8'h3E;  // B
        8'h43:   g = 8'h9C;  // C
        8'h44:   g = 8'h7A;  // D
        8'h45:   g = 8'h9E;  // E
        8'h46:   g = 8'h8E;  // F
        8'h47:   g = 8'hF6;  // G
        8'h48:   g = 8'h6E;  // H
        8'h49:   g = 8'h0C;  // I
        8'h4A:   g = 8'h70;  // J
        8'h4C:   g = 8'h1C;  // L
        8'h4E:   g = 8'h2A;  // N
        8'h4F:   g = 8'hFC;  // O
        8'h50:   g = 8'hCE;  // P
        8'h51:   g = 8'hE6;  // Q
        8'h52:   g = 8'h0A;  // R
        8'h53:   g = 8'hB6;  // S
        8'h54:   g = 8'h1E;  // T
        8'h55:   g = 8'h38;  // U
        8'h56:   g = 8'h7C;  // V
        8'h59:   g = 8'h76;  // Y
        8'h2E:   g = 8'hC6;  // '.' degree sign
        8'h2D:   g = 8'h02;  // '-'
        8'h30:   g = 8'hFC;  // '0'
        default: g = 8'h00;  // space and everything else
      endcase
    end
    return g;
  endfunction

endpackage

`default_nettype wire

/* rtl/cssf_front.sv */
`default_nettype none

module cssf_front (
  input  wire logic                                    clk_i,
  input  wire logic                                    en_i,
  input  wire logic [1:0]                              time_format_i,
  input  wire logic                                    date_format_i,
  input  wire cssf_pkg::command_e                      cmd_i,
  input  wire logic [cssf_pkg::NumDigits-1:0]          dots_i,
  input  wire logic [cssf_pkg::NumDigits-1:0][7:0]     chars_i,
  input  wire logic [4:0]                              value_a_i,
  input  wire logic [5:0]                              value_b_i,
  input  wire logic [13:0]                             value_c_i,
  output cssf_pkg::lane_word_t                         word_o
);

  // stage 1 (comb): hour fixup, small splits, value_c / 10
  logic [4:0]                hour;
  logic [5:0]                hi_val, mid_val;
  logic                      lead_blank;
  cssf_pkg::digit_t [1:0]    hi_dig, mid_dig;
  logic [26:0]               prod_c;

  always_comb begin
    hour = value_a_i;
    if (time_format_i != cssf_pkg::TF_24H) begin
      if (value_a_i > 5'd12) begin
        hour = value_a_i - 5'd12;
      end else if (value_a_i == 5'd0) begin
        hour = 5'd12;
      end
    end
    hi_val     = {1'b0, value_a_i};
    mid_val    = value_b_i;
    lead_blank = 1'b0;
    if (cmd_i == cssf_pkg::CMD_TIME) begin
      hi_val     = {1'b0, hour};
      lead_blank = (time_format_i == cssf_pkg::TF_12H_BLANK) && (hour < 5'd10);
    end else if (date_format_i != cssf_pkg::DF_DMY) begin
      hi_val  = value_b_i;
      mid_val = {1'b0, value_a_i};
    end
    hi_dig    = cssf_pkg::split_small(hi_val);
    mid_dig   = cssf_pkg::split_small(mid_val);
    hi_dig[1].blank = lead_blank;
    prod_c    = {13'd0, value_c_i} * 27'd6554;
  end

  cssf_pkg::command_e                     cmd1_q, cmd2_q;
  logic [cssf_pkg::NumDigits-1:0]         dots1_q, dots2_q;
  logic [cssf_pkg::NumDigits-1:0][7:0]    chars1_q, chars2_q;
  cssf_pkg::digit_t [3:0]                 upper1_q, upper2_q;
  logic [3:0]                             c_lo1_q;
  logic [10:0]                            q10_1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q   <= cmd_i;
      dots1_q  <= dots_i;
      chars1_q <= chars_i;
      upper1_q <= {hi_dig, mid_dig};
      c_lo1_q  <= value_c_i[3:0];
      q10_1_q  <= prod_c[26:16];
    end
  end

  // stage 2 (comb): value_c % 10, q10 / 10
  logic [7:0]   q10x10;
  logic [23:0]  prod_q;

  always_comb begin
    q10x10 = {4'd0, q10_1_q[3:0]} * 8'd10;
    prod_q = {13'd0, q10_1_q} * 24'd6554;
  end

  logic [3:0]   ones2_q;
  logic [3:0]   q10_lo2_q;
  logic         tens_over2_q;
  logic [7:0]   q100_2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd2_q       <= cmd1_q;
      dots2_q      <= dots1_q;
      chars2_q     <= chars1_q;
      upper2_q     <= upper1_q;
      ones2_q      <= c_lo1_q - q10x10[3:0];
      q10_lo2_q    <= q10_1_q[3:0];
      tens_over2_q <= (q10_1_q >= 11'd10);
      q100_2_q     <= prod_q[23:16];
    end
  end

  // stage 3 (comb): tens digit of value_c for seconds or year
  logic [7:0]   q100x10;
  logic [3:0]   year_tens;

  always_comb begin
    q100x10   = {4'd0, q100_2_q[3:0]} * 8'd10;
    year_tens = q10_lo2_q - q100x10[3:0];
    word_o.cmd    = cmd2_q;
    word_o.dots   = dots2_q;
    word_o.chars  = chars2_q;
    word_o.digits[5:2] = upper2_q;
    word_o.digits[0]   = '{value: ones2_q, blank: 1'b0};
    if (cmd2_q == cssf_pkg::CMD_TIME) begin
      word_o.digits[1] = '{value: q10_lo2_q, blank: tens_over2_q};
    end else begin
      word_o.digits[1] = '{value: year_tens, blank: 1'b0};
    end
  end

endmodule

`default_nettype wire

/* rtl/cssf_lane.sv */
`default_nettype none

module cssf_lane (
  input  wire cssf_pkg::command_e  cmd_i,
  input  wire cssf_pkg::digit_t    digit_i,
  input  wire logic [7:0]          char_i,
  input  wire logic                dot_i,
  output logic [7:0]               seg_o
);

  logic [7:0] glyph;

  always_comb begin
    case (cmd_i)
      cssf_pkg::CMD_TIME,
      cssf_pkg::CMD_DATE: begin
        glyph = digit_i.blank ? 8'h00 : cssf_pkg::glyph_of_digit(digit_i.value);
      end
      cssf_pkg::CMD_MSG: begin
        glyph = cssf_pkg::glyph_of_char(char_i);
      end
      default: begin
        glyph = 8'h00;
      end
    endcase
    seg_o = {glyph[7:1], glyph[0] | dot_i};
  end

endmodule

`default_nettype wire

/* rtl/clock_seven_segment_formatter.sv */
// An accepted word passes stage 1, stage 2 and then the output register before it
//   is presented on the outputs. One word per cycle while out_ready_i is high; the
//   whole pipe stalls as one while the output register holds an untaken word.
// Reset (rst_ni low, asynchronous): pipe valid bits and both format
//   registers clear to 0 (24-hour time, day-month-year date).
`default_nettype none

module clock_seven_segment_formatter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [1:0]  cfg_data_i,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [5:0]  dot_mask_i,
  input  wire logic [4:0]  value_a_i,
  input  wire logic [5:0]  value_b_i,
  input  wire logic [13:0] value_c_i,
  input  wire logic [7:0]  char_0_i,
  input  wire logic [7:0]  char_1_i,
  input  wire logic [7:0]  char_2_i,
  input  wire logic [7:0]  char_3_i,
  input  wire logic [7:0]  char_4_i,
  input  wire logic [7:0]  char_5_i,
  // output words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       seg_0_o,
  output logic [7:0]       seg_1_o,
  output logic [7:0]       seg_2_o,
  output logic [7:0]       seg_3_o,
  output logic [7:0]       seg_4_o,
  output logic [7:0]       seg_5_o
);

  // ---------------------------------------------------------------------------
  // Config registers. Writes must land only while the pipe is empty (the user is bound;
  // the block itself does not enforce it), so stage 1 reads them live.
  // ---------------------------------------------------------------------------
  logic [1:0] time_format_q;
  logic       date_format_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_format_q <= 2'd0;
      date_format_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cssf_pkg::CFG_TIME_FORMAT) begin
        time_format_q <= cfg_data_i;
      end else begin
        date_format_q <= cfg_data_i[0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe control: three register stages (two in the front end, one output
  // register). Everything advances together whenever the output register is
  // empty or being drained this cycle.
  // ---------------------------------------------------------------------------
  logic pipe_en;
  logic v1_q, v2_q, v3_q;

  assign pipe_en    = !v3_q || out_ready_i;
  assign in_ready_o = pipe_en;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: digit extraction. Chars are reordered so index k feeds the
  // lane for segment k (char_0 is the leftmost digit, segment 5).
  // ---------------------------------------------------------------------------
  logic [cssf_pkg::NumDigits-1:0][7:0] chars;
  cssf_pkg::lane_word_t                word;

  assign chars = {char_0_i, char_1_i, char_2_i, char_3_i, char_4_i, char_5_i};

  cssf_front u_front (
    .clk_i         (clk_i),
    .en_i          (pipe_en),
    .time_format_i (time_format_q),
    .date_format_i (date_format_q),
    .cmd_i         (cssf_pkg::command_e'(command_i)),
    .dots_i        (dot_mask_i),
    .chars_i       (chars),
    .value_a_i     (value_a_i),
    .value_b_i     (value_b_i),
    .value_c_i     (value_c_i),
    .word_o        (word)
  );

  // ---------------------------------------------------------------------------
  // Six glyph lanes in parallel, one per digit position.
  // ---------------------------------------------------------------------------
  logic [cssf_pkg::NumDigits-1:0][7:0] lane_seg;

  for (genvar k = 0; k < cssf_pkg::NumDigits; k++) begin : g_lane
    cssf_lane u_lane (
      .cmd_i   (word.cmd),
      .digit_i (word.digits[k]),
      .char_i  (word.chars[k]),
      .dot_i   (word.dots[k]),
      .seg_o   (lane_seg[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge: collect the lane bytes into the output register.
  // ---------------------------------------------------------------------------
  logic [cssf_pkg::NumDigits-1:0][7:0] seg_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      seg_q <= lane_seg;
    end
  end

  assign seg_0_o = seg_q[0];
  assign seg_1_o = seg_q[1];
  assign seg_2_o = seg_q[2];
  assign seg_3_o = seg_q[3];
  assign seg_4_o = seg_q[4];
  assign seg_5_o = seg_q[5];

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_accept_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted word did not enter stage 1");

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  a_stage2_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && pipe_en) |=> out_valid_o)
    else $error("stage 2 word lost before output");

  a_drained_word_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !v2_q) |=> !out_valid_o)
    else $error("output word repeated");

endmodule

`default_nettype wire
